### rtl/r2fft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and elaboration-time helpers for the zero-padded
// radix-2 FFT: command struct, status codes, twiddle generation, sample extension, saturation.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int MaxPointsDefault = 1024;
  localparam int SampleBits       = 16;
  localparam int ValW             = 27;
  localparam int CoefW            = 17;
  localparam int ProdW            = ValW + CoefW;
  localparam int TwW              = 15;
  localparam longint unsigned PiQ30 = 64'd3373259426;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    WSEL_SAMPLE = 3'd0,
    WSEL_ZERO   = 3'd1,
    WSEL_RDATA  = 3'd2,
    WSEL_UA     = 3'd3,
    WSEL_TOP    = 3'd4,
    WSEL_BOT    = 3'd5
  } wsel_e;

  typedef struct packed {
    logic        wr_en;
    wsel_e       wsel;
    logic        cap_a;
    logic        tw_ld;
    logic        mul_en;
    logic        out_ld;
    status_e     res_status;
    logic [10:0] res_points;
    logic        res_ovf;
  } cmd_t;

  function automatic int pow2ceil(input int n);
    int p;
    p = 2;
    while (p < n) p = p * 2;
    return p;
  endfunction

  // Quarter-wave sine entry, Taylor series in unsigned Q30, rounded to Q15
  function automatic logic [TwW-1:0] qsin(input int t, input int rb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    x    = (longint'(t) * PiQ30) >> (rb - 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
    if (sum < 0) begin
      r = 0;
    end else begin
      r = (sum + 16384) >>> 15;
    end
    if (r > 32767) r = 32767;
    return r[TwW-1:0];
  endfunction

  // Low SampleBits of the port, sign-extended when they fit within the port
  function automatic logic [ValW-1:0] ext_sample(input logic [15:0] s);
    logic [31:0]     w;
    logic [ValW-1:0] r;
    w = {16'b0, s};
    for (int i = 0; i < ValW; i++) begin
      if (i < SampleBits) begin
        r[i] = w[i];
      end else begin
        r[i] = (SampleBits <= 16) ? w[SampleBits-1] : 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic signed [ValW-1:0] sat27(input logic signed [31:0] v);
    if (v > 32'sd67108863) return 27'sd67108863;
    if (v < -32'sd67108864) return -27'sd67108864;
    return v[ValW-1:0];
  endfunction

endpackage

### rtl/radix2_fft_zero_padded.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_zero_padded
// Loads real samples into a work memory, pads to a power of two and runs an
// in-place radix-2 decimation-in-time FFT; reads return one bin at a time.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid_i/in_stall_o  cmd, sample, last, bin_index
//   out      from block out_valid_o/out_stall_i real_part, imag_part, points,
//                                              status, overflowed
//
// A load writes the sample directly; a read fetches the bin, then loads the
// output register. A last sample starts the transform: size search, zero
// padding of each padded entry, bit-reversed reordering by swapped pairs, then
// N/2 * log2 N butterflies, each reading both legs, multiplying, writing both.
// Reset is asynchronous, active low; the work memory is not cleared.
// Input is stalled while a transform runs, and a read is stalled while a
// result waits in the output register.
// ----------------------------------------------------------------------------
module radix2_fft_zero_padded #(
  parameter int MAX_POINTS = r2fft_pkg::MaxPointsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic signed [15:0] sample_i,
  input  logic               last_i,
  input  logic [9:0]         bin_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [26:0] real_part_o,
  output logic signed [26:0] imag_part_o,
  output logic [10:0]        points_o,
  output logic [1:0]         status_o,
  output logic               overflowed_o
);

  localparam int P2 = r2fft_pkg::pow2ceil(MAX_POINTS);
  localparam int AW = $clog2(P2);
  localparam int RB = (AW < 2) ? 2 : AW;
  localparam int QW = RB - 1;

  r2fft_pkg::cmd_t ctl;
  logic [AW-1:0]   raddr, waddr;
  logic [QW-1:0]   tw_idx;

  r2fft_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .last_i      (last_i),
    .bin_index_i (bin_index_i),
    .out_full_i  (out_valid_o),
    .ctl_o       (ctl),
    .raddr_o     (raddr),
    .waddr_o     (waddr),
    .tw_idx_o    (tw_idx)
  );

  r2fft_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .raddr_i      (raddr),
    .waddr_i      (waddr),
    .tw_idx_i     (tw_idx),
    .sample_i     (sample_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .real_part_o  (real_part_o),
    .imag_part_o  (imag_part_o),
    .points_o     (points_o),
    .status_o     (status_o),
    .overflowed_o (overflowed_o)
  );

endmodule

### rtl/r2fft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer: record loading, bin reads, size search, zero padding, bit-reversed
// reordering and butterfly scheduling over the single-port work memory.
// ----------------------------------------------------------------------------
module r2fft_ctrl #(
  parameter int MAX_POINTS = r2fft_pkg::MaxPointsDefault,
  localparam int P2 = r2fft_pkg::pow2ceil(MAX_POINTS),
  localparam int AW = $clog2(P2),
  localparam int RB = (AW < 2) ? 2 : AW,
  localparam int QW = RB - 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   cmd_i,
  input  logic                   last_i,
  input  logic [9:0]             bin_index_i,
  input  logic                   out_full_i,
  output r2fft_pkg::cmd_t        ctl_o,
  output logic [AW-1:0]          raddr_o,
  output logic [AW-1:0]          waddr_o,
  output logic [QW-1:0]          tw_idx_o
);

  localparam int CW  = AW + 1;
  localparam int BTW = $clog2(AW + 1);
  localparam int PW  = (CW > 11) ? CW : 11;
  localparam int BW  = (AW > 10) ? AW : 10;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_RD     = 14'b00000000000010,
    S_SIZE   = 14'b00000000000100,
    S_PAD    = 14'b00000000001000,
    S_REV_RA = 14'b00000000010000,
    S_REV_RB = 14'b00000000100000,
    S_REV_WA = 14'b00000001000000,
    S_REV_WB = 14'b00000010000000,
    S_BF_RA  = 14'b00000100000000,
    S_BF_RB  = 14'b00001000000000,
    S_BF_M   = 14'b00010000000000,
    S_BF_WA  = 14'b00100000000000,
    S_BF_WB  = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       size_q, size_d;
  logic [BTW-1:0]      bits_q, bits_d;
  logic [BTW-1:0]      stage_q, stage_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       j_q, j_d;
  logic                ready_q, ready_d;
  logic                ovf_q, ovf_d;
  r2fft_pkg::status_e  rdst_q, rdst_d;

  logic                accept;
  logic [CW-1:0]       eff_cnt;
  logic                eff_ovf;
  logic [BW-1:0]       bin_x;
  logic [PW-1:0]       size_x;
  logic [PW-1:0]       bin_p;
  logic [AW-1:0]       fwd, rev_full, rev;
  logic [AW-1:0]       b, mask, top, bot;
  logic [AW+RB-1:0]    tw_full;

  assign in_stall_o = (state_q != S_IDLE) || (cmd_i && out_full_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign eff_cnt = ready_q ? '0 : count_q;
  assign eff_ovf = ready_q ? 1'b0 : ovf_q;
  assign bin_x   = BW'(bin_index_i);
  assign size_x  = PW'(size_q);
  assign bin_p   = PW'(bin_index_i);

  always_comb begin
    fwd = idx_q[AW-1:0];
    for (int k = 0; k < AW; k++) begin
      rev_full[k] = fwd[AW-1-k];
    end
    rev = rev_full >> (BTW'(AW) - bits_q);
  end

  // Butterfly index: insert a zero at the stage bit to get the top leg
  assign b       = idx_q[AW-1:0];
  assign mask    = (AW'(1) << stage_q) - AW'(1);
  assign top     = ((b >> stage_q) << (stage_q + 1'b1)) | (b & mask);
  assign bot     = top | (AW'(1) << stage_q);
  assign tw_full = (AW+RB)'(b & mask) << (RB - 1 - int'(stage_q));
  assign tw_idx_o = tw_full[QW-1:0];

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    size_d  = size_q;
    bits_d  = bits_q;
    stage_d = stage_q;
    idx_d   = idx_q;
    j_d     = j_q;
    ready_d = ready_q;
    ovf_d   = ovf_q;
    rdst_d  = rdst_q;
    raddr_o = idx_q[AW-1:0];
    waddr_o = idx_q[AW-1:0];
    ctl_o            = '0;
    ctl_o.wsel       = r2fft_pkg::WSEL_ZERO;
    ctl_o.res_status = rdst_q;
    ctl_o.res_points = ready_q ? size_x[10:0] : 11'd0;
    ctl_o.res_ovf    = ovf_q;

    unique case (state_q)
      S_IDLE: begin
        raddr_o = bin_x[AW-1:0];
        if (accept) begin
          if (!cmd_i) begin
            if (ready_q) begin
              ready_d = 1'b0;
              size_d  = '0;
            end
            if (eff_cnt < CW'(MAX_POINTS)) begin
              ctl_o.wr_en = 1'b1;
              ctl_o.wsel  = r2fft_pkg::WSEL_SAMPLE;
              waddr_o     = eff_cnt[AW-1:0];
              count_d     = eff_cnt + 1'b1;
              ovf_d       = eff_ovf;
            end else begin
              count_d = eff_cnt;
              ovf_d   = 1'b1;
            end
            if (last_i) begin
              size_d  = CW'(1);
              bits_d  = '0;
              state_d = S_SIZE;
            end
          end else begin
            if (!ready_q) begin
              rdst_d = r2fft_pkg::ST_EMPTY;
            end else if (bin_p >= size_x) begin
              rdst_d = r2fft_pkg::ST_RANGE;
            end else begin
              rdst_d = r2fft_pkg::ST_OK;
            end
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        ctl_o.out_ld = 1'b1;
        state_d      = S_IDLE;
      end
      S_SIZE: begin
        if (size_q < count_q) begin
          size_d = size_q << 1;
          bits_d = bits_q + 1'b1;
        end else begin
          idx_d   = count_q;
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        if (idx_q < size_q) begin
          ctl_o.wr_en = 1'b1;
          ctl_o.wsel  = r2fft_pkg::WSEL_ZERO;
          idx_d       = idx_q + 1'b1;
        end else begin
          idx_d   = '0;
          state_d = S_REV_RA;
        end
      end
      S_REV_RA: begin
        if (idx_q == size_q) begin
          idx_d   = '0;
          stage_d = '0;
          state_d = (bits_q == '0) ? S_FIN : S_BF_RA;
        end else if (CW'(rev) > idx_q) begin
          j_d     = rev;
          state_d = S_REV_RB;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_REV_RB: begin
        raddr_o     = j_q;
        ctl_o.cap_a = 1'b1;
        state_d     = S_REV_WA;
      end
      S_REV_WA: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wsel  = r2fft_pkg::WSEL_RDATA;
        state_d     = S_REV_WB;
      end
      S_REV_WB: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wsel  = r2fft_pkg::WSEL_UA;
        waddr_o     = j_q;
        idx_d       = idx_q + 1'b1;
        state_d     = S_REV_RA;
      end
      S_BF_RA: begin
        raddr_o     = top;
        ctl_o.tw_ld = 1'b1;
        state_d     = S_BF_RB;
      end
      S_BF_RB: begin
        raddr_o     = bot;
        ctl_o.cap_a = 1'b1;
        state_d     = S_BF_M;
      end
      S_BF_M: begin
        ctl_o.mul_en = 1'b1;
        state_d      = S_BF_WA;
      end
      S_BF_WA: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wsel  = r2fft_pkg::WSEL_TOP;
        waddr_o     = top;
        state_d     = S_BF_WB;
      end
      S_BF_WB: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wsel  = r2fft_pkg::WSEL_BOT;
        waddr_o     = bot;
        state_d     = S_BF_RA;
        if ((idx_q + 1'b1) == (size_q >> 1)) begin
          idx_d = '0;
          if (stage_q == (bits_q - 1'b1)) begin
            state_d = S_FIN;
          end else begin
            stage_d = stage_q + 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FIN: begin
        ready_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      size_q  <= '0;
      bits_q  <= '0;
      stage_q <= '0;
      idx_q   <= '0;
      j_q     <= '0;
      ready_q <= 1'b0;
      ovf_q   <= 1'b0;
      rdst_q  <= r2fft_pkg::ST_EMPTY;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      size_q  <= size_d;
      bits_q  <= bits_d;
      stage_q <= stage_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      ready_q <= ready_d;
      ovf_q   <= ovf_d;
      rdst_q  <= rdst_d;
    end
  end

endmodule

### rtl/r2fft_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_dp
// Datapath: complex work memory, quarter-wave twiddle ROM, butterfly
// multipliers with rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module r2fft_dp #(
  parameter int MAX_POINTS = r2fft_pkg::MaxPointsDefault,
  localparam int P2 = r2fft_pkg::pow2ceil(MAX_POINTS),
  localparam int AW = $clog2(P2),
  localparam int RB = (AW < 2) ? 2 : AW,
  localparam int QW = RB - 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  r2fft_pkg::cmd_t        ctl_i,
  input  logic [AW-1:0]          raddr_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [QW-1:0]          tw_idx_i,
  input  logic [15:0]            sample_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic signed [26:0]     real_part_o,
  output logic signed [26:0]     imag_part_o,
  output logic [10:0]            points_o,
  output logic [1:0]             status_o,
  output logic                   overflowed_o
);

  localparam int Q   = (1 << RB) / 4;
  localparam int VW  = r2fft_pkg::ValW;
  localparam int CFW = r2fft_pkg::CoefW;
  localparam int PRW = r2fft_pkg::ProdW;

  logic [2*VW-1:0]         mem [P2];
  logic [2*VW-1:0]         rdata_q;
  logic [2*VW-1:0]         wdata;
  logic signed [VW-1:0]    ur_q, ui_q;
  logic signed [VW-1:0]    br, bi;
  logic signed [CFW-1:0]   c_q, s_q;
  logic signed [PRW-1:0]   p_cbr_q, p_sbi_q, p_cbi_q, p_sbr_q;
  logic signed [PRW+1:0]   sum_r, sum_i;
  logic signed [31:0]      tr, ti;
  logic signed [VW-1:0]    top_r, top_i, bot_r, bot_i;

  logic [r2fft_pkg::TwW-1:0] rom [Q+1];
  logic                      tw_le;
  logic [QW-1:0]             ci, si;
  logic [QW:0]               si_w;
  logic signed [CFW-1:0]     cmag;

  logic                    out_valid_q;
  logic signed [VW-1:0]    re_q, im_q;
  logic [10:0]             points_q;
  logic [1:0]              status_q;
  logic                    ovf_q;

  for (genvar gi = 0; gi <= Q; gi++) begin : g_rom
    assign rom[gi] = r2fft_pkg::qsin(gi, RB);
  end

  // Cosine and sine by quarter-wave symmetry
  assign tw_le = (tw_idx_i <= QW'(Q));
  assign si_w  = (QW+1)'(2 * Q) - {1'b0, tw_idx_i};
  assign ci    = tw_le ? (QW'(Q) - tw_idx_i) : (tw_idx_i - QW'(Q));
  assign si    = tw_le ? tw_idx_i : si_w[QW-1:0];
  assign cmag  = CFW'(rom[ci]);

  assign br = rdata_q[2*VW-1:VW];
  assign bi = rdata_q[VW-1:0];

  // Round to nearest, ties towards plus infinity, keeping the sign
  assign sum_r = (PRW+2)'(p_cbr_q) + (PRW+2)'(p_sbi_q) + (PRW+2)'(16384);
  assign sum_i = (PRW+2)'(p_cbi_q) - (PRW+2)'(p_sbr_q) + (PRW+2)'(16384);
  assign tr    = 32'(sum_r >>> 15);
  assign ti    = 32'(sum_i >>> 15);
  assign top_r = r2fft_pkg::sat27(32'(ur_q) + tr);
  assign top_i = r2fft_pkg::sat27(32'(ui_q) + ti);
  assign bot_r = r2fft_pkg::sat27(32'(ur_q) - tr);
  assign bot_i = r2fft_pkg::sat27(32'(ui_q) - ti);

  always_comb begin
    case (ctl_i.wsel)
      r2fft_pkg::WSEL_SAMPLE: wdata = {r2fft_pkg::ext_sample(sample_i), {VW{1'b0}}};
      r2fft_pkg::WSEL_RDATA:  wdata = rdata_q;
      r2fft_pkg::WSEL_UA:     wdata = {ur_q, ui_q};
      r2fft_pkg::WSEL_TOP:    wdata = {top_r, top_i};
      r2fft_pkg::WSEL_BOT:    wdata = {bot_r, bot_i};
      default:                wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_a) begin
      ur_q <= rdata_q[2*VW-1:VW];
      ui_q <= rdata_q[VW-1:0];
    end
    if (ctl_i.tw_ld) begin
      c_q <= tw_le ? cmag : -cmag;
      s_q <= CFW'(rom[si]);
    end
    if (ctl_i.mul_en) begin
      p_cbr_q <= PRW'(c_q * br);
      p_sbi_q <= PRW'(s_q * bi);
      p_cbi_q <= PRW'(c_q * bi);
      p_sbr_q <= PRW'(s_q * br);
    end
    if (ctl_i.out_ld) begin
      if (ctl_i.res_status == r2fft_pkg::ST_OK) begin
        re_q <= rdata_q[2*VW-1:VW];
        im_q <= rdata_q[VW-1:0];
      end else begin
        re_q <= '0;
        im_q <= '0;
      end
      points_q <= ctl_i.res_points;
      status_q <= ctl_i.res_status;
      ovf_q    <= ctl_i.res_ovf;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign real_part_o  = re_q;
  assign imag_part_o  = im_q;
  assign points_o     = points_q;
  assign status_o     = status_q;
  assign overflowed_o = ovf_q;

endmodule
